// ----- rtl/bvem_pkg.sv -----
// bvem_pkg: shared types and constants of the battery voltage ema monitor
// holds the state and operation enums, the command/status structs and register indexes
// no dependencies
package bvem_pkg;

    // stream payload widths
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned PIN_W     = 13;
    localparam int unsigned MV_W      = 16;
    localparam int unsigned FILT_W    = 24;
    localparam int unsigned TOTAL_W   = 20;
    localparam int unsigned PROD_W    = 41;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 24;

    // apb register map
    localparam int unsigned PADDR_W = 5;
    localparam int unsigned PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_SAMPLE_INTERVAL = 3'd0,
        REG_DIVIDER_SCALE   = 3'd1,
        REG_EMA_ALPHA       = 3'd2,
        REG_LOW_START       = 3'd3,
        REG_ALTERNATOR_MIN  = 3'd4,
        REG_MOCK_ENABLE     = 3'd5,
        REG_MOCK_MV         = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] sample_interval_ms;
        logic [15:0] divider_scale_q8;
        logic [15:0] ema_alpha_q16;
        logic [15:0] low_start_mv;
        logic [15:0] alternator_min_mv;
        logic        mock_enable;
        logic [15:0] mock_mv;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCALE,
        ST_SAT,
        ST_WARM,
        ST_EMA_A,
        ST_EMA_B,
        ST_EMA_C,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_SCALE,
        OP_SAT,
        OP_WARM,
        OP_EMA_A,
        OP_EMA_B,
        OP_EMA_C,
        OP_DIVIDE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic in_ready;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic elapsed;
        logic mock;
        logic warm;
        logic warm_last;
    } status_t;

endpackage

// ----- rtl/bvem_ctrl.sv -----
// bvem_ctrl: sequencing state machine of the battery voltage ema monitor
// steps one item through check, scale, warm-up or ema, divide and result
// depends on bvem_pkg
module bvem_ctrl
    import bvem_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    out_free,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.op = OP_CHECK;
                if (status.elapsed && !status.mock) begin
                    state_next = ST_SCALE;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SCALE: begin
                cmd.op     = OP_SCALE;
                state_next = ST_SAT;
            end
            ST_SAT: begin
                cmd.op     = OP_SAT;
                state_next = status.warm ? ST_WARM : ST_EMA_A;
            end
            ST_WARM: begin
                cmd.op     = OP_WARM;
                state_next = status.warm_last ? ST_DIVIDE : ST_RESULT;
            end
            ST_EMA_A: begin
                cmd.op     = OP_EMA_A;
                state_next = ST_EMA_B;
            end
            ST_EMA_B: begin
                cmd.op     = OP_EMA_B;
                state_next = ST_EMA_C;
            end
            ST_EMA_C: begin
                cmd.op     = OP_EMA_C;
                state_next = ST_RESULT;
            end
            ST_DIVIDE: begin
                cmd.op     = OP_DIVIDE;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/bvem_dp.sv -----
// bvem_dp: datapath of the battery voltage ema monitor
// filter state, shared multiplier, warm-up sum and reciprocal multiply for the warm-up mean
// depends on bvem_pkg
module bvem_dp
    import bvem_pkg::*;
#(
    parameter int unsigned WARMUP_SAMPLES = 6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cmd_t                     cmd,
    input  cfg_t                     cfg,
    input  logic [NOW_W-1:0]         in_now_ms,
    input  logic signed [PIN_W-1:0]  in_pin_mv,
    output status_t                  status,
    output logic                     res_sample_taken,
    output logic [MV_W-1:0]          res_filtered_mv,
    output logic                     res_reading_valid,
    output logic                     res_low_for_start,
    output logic                     res_alternator_charging
);

    localparam int unsigned SEEN_W = $clog2(WARMUP_SAMPLES + 1);
    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(WARMUP_SAMPLES);
    localparam logic [SEEN_W-1:0] SEEN_LAST = SEEN_W'(WARMUP_SAMPLES - 1);

    // warm-up mean floor(total * 256 / n) as (total * ceil(2^(28+l) / n)) >> (20 + l),
    // l = ceil(log2 n); exact for every 20-bit total
    localparam int unsigned MEAN_L     = $clog2(WARMUP_SAMPLES);
    localparam int unsigned MEAN_SHIFT = TOTAL_W + MEAN_L;
    localparam int unsigned RECIP_W    = TOTAL_W + 9;
    localparam int unsigned MEAN_W     = TOTAL_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (TOTAL_W + 8 + MEAN_L)) + 64'(WARMUP_SAMPLES) - 64'd1)
        / 64'(WARMUP_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    // model state
    logic [NOW_W-1:0]   last_reg, last_next;
    logic [FILT_W-1:0]  filt_reg, filt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic               valid_reg, valid_next;
    logic               taken_reg, taken_next;

    // working registers
    logic [NOW_W-1:0]        now_reg, now_next;
    logic signed [PIN_W-1:0] pin_reg, pin_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [MV_W-1:0]         mv_reg, mv_next;

    logic [NOW_W-1:0]   delta;
    logic               elapsed;
    logic [11:0]        pin_clamp;
    logic [FILT_W-1:0]  mul_a;
    logic [16:0]        mul_b;
    logic [PROD_W-1:0]  mul_out;
    logic [MV_W-1:0]    mv_sat;
    logic [TOTAL_W-1:0] total_sum;
    logic [PROD_W-1:0]  ema_sum;
    logic [MEAN_W-1:0]  mean_prod;
    logic [MEAN_W-1:0]  mean_q;

    // interval check, modulo 2^32
    assign delta   = now_reg - last_reg;
    assign elapsed = delta >= {16'h0000, cfg.sample_interval_ms};

    // shared multiplier operand select
    assign pin_clamp = pin_reg[PIN_W-1] ? 12'd0 : pin_reg[11:0];
    always_comb begin
        case (cmd.op)
            OP_EMA_A: begin
                mul_a = filt_reg;
                mul_b = 17'h10000 - {1'b0, cfg.ema_alpha_q16};
            end
            OP_EMA_B: begin
                mul_a = {8'h00, mv_reg};
                mul_b = {1'b0, cfg.ema_alpha_q16};
            end
            default: begin
                mul_a = {12'h000, pin_clamp};
                mul_b = {1'b0, cfg.divider_scale_q8};
            end
        endcase
    end
    assign mul_out = mul_a * mul_b;

    // scaled reading, saturated to 16 bits
    assign mv_sat = (|prod_reg[27:24]) ? 16'hFFFF : prod_reg[23:8];

    assign total_sum = total_reg + {4'h0, mv_reg};
    assign ema_sum   = acc_reg + {prod_reg[32:0], 8'h00} + 41'd32768;

    // warm-up mean by constant reciprocal
    assign mean_prod = total_reg * RECIP;
    assign mean_q    = mean_prod >> MEAN_SHIFT;

    // next state of all registers
    always_comb begin
        last_next  = last_reg;
        filt_next  = filt_reg;
        total_next = total_reg;
        seen_next  = seen_reg;
        valid_next = valid_reg;
        taken_next = taken_reg;
        now_next   = now_reg;
        pin_next   = pin_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        mv_next    = mv_reg;
        case (cmd.op)
            OP_LOAD: begin
                now_next = in_now_ms;
                pin_next = in_pin_mv;
            end
            OP_CHECK: begin
                taken_next = elapsed;
                if (elapsed) begin
                    last_next = now_reg;
                    if (cfg.mock_enable) begin
                        filt_next  = {cfg.mock_mv, 8'h00};
                        valid_next = 1'b1;
                        total_next = '0;
                        seen_next  = SEEN_FULL;
                    end
                end
            end
            OP_SCALE: begin
                prod_next = mul_out;
            end
            OP_SAT: begin
                mv_next = mv_sat;
            end
            OP_WARM: begin
                total_next = total_sum;
                seen_next  = seen_reg + 1'b1;
            end
            OP_EMA_A: begin
                prod_next = mul_out;
            end
            OP_EMA_B: begin
                acc_next  = prod_reg;
                prod_next = mul_out;
            end
            OP_EMA_C: begin
                filt_next = ema_sum[39:16];
            end
            OP_DIVIDE: begin
                filt_next  = mean_q[FILT_W-1:0];
                valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // filter state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            filt_reg  <= '0;
            total_reg <= '0;
            seen_reg  <= '0;
            valid_reg <= 1'b0;
            taken_reg <= 1'b0;
        end else begin
            last_reg  <= last_next;
            filt_reg  <= filt_next;
            total_reg <= total_next;
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
            taken_reg <= taken_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        now_reg  <= now_next;
        pin_reg  <= pin_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        mv_reg   <= mv_next;
    end

    // status to the controller
    assign status.elapsed   = elapsed;
    assign status.mock      = cfg.mock_enable;
    assign status.warm      = seen_reg < SEEN_FULL;
    assign status.warm_last = seen_reg == SEEN_LAST;

    // result fields from the current state
    assign res_sample_taken        = taken_reg;
    assign res_filtered_mv         = filt_reg[FILT_W-1:8];
    assign res_reading_valid       = valid_reg;
    assign res_low_for_start       = !valid_reg || (filt_reg[FILT_W-1:8] < cfg.low_start_mv);
    assign res_alternator_charging = valid_reg &&
                                     (filt_reg[FILT_W-1:8] >= cfg.alternator_min_mv);

    // once valid, the filter stays valid
    assert property (@(posedge aclk) disable iff (!aresetn) valid_reg |=> valid_reg)
        else $error("filter valid flag dropped");

    // warm-up count never passes the warm-up length
    assert property (@(posedge aclk) disable iff (!aresetn) seen_reg <= SEEN_FULL)
        else $error("warm-up count out of range");

    // filter holds zero until a first value is available
    assert property (@(posedge aclk) disable iff (!aresetn) !valid_reg |-> filt_reg == '0)
        else $error("filter written before valid");

endmodule

// ----- rtl/battery_voltage_ema_monitor_top.sv -----
// path from input accept to the result register, ending in result: check alone when the
// interval has not elapsed or mock mode is on; check, scale, saturate and warm-up during
// warm-up, plus divide on the last warm-up item (mean by reciprocal multiply); check, scale,
// saturate and ema a, b, c on the ema path (one shared multiplier, used three times)
// one item at a time, taken in idle; a result waiting on m_tready holds the next one back
// aresetn (synchronous, active low) restores register defaults and clears the filter state
// battery_voltage_ema_monitor_top: stream ports, apb registers and result register
// depends on bvem_pkg, bvem_ctrl, bvem_dp
module battery_voltage_ema_monitor_top
    import bvem_pkg::*;
#(
    parameter int unsigned WARMUP_SAMPLES = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // item in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // now_ms[31:0], pin_mv[44:32], zero pad
    // item out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // sample_taken[0], filtered_mv[16:1],
                                            // reading_valid[17], low_for_start[18],
                                            // alternator_charging[19], zero pad
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_write;

    cmd_t     cmd;
    status_t  status;
    logic     out_free;

    logic              res_sample_taken;
    logic [MV_W-1:0]   res_filtered_mv;
    logic              res_reading_valid;
    logic              res_low_for_start;
    logic              res_alternator_charging;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // register writes
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_interval_ms <= 16'd80;
            cfg_reg.divider_scale_q8   <= 16'd1536;
            cfg_reg.ema_alpha_q16      <= 16'd7864;
            cfg_reg.low_start_mv       <= 16'd12000;
            cfg_reg.alternator_min_mv  <= 16'd13200;
            cfg_reg.mock_enable        <= 1'b1;
            cfg_reg.mock_mv            <= 16'd14200;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_SAMPLE_INTERVAL: cfg_reg.sample_interval_ms <= pwdata[15:0];
                REG_DIVIDER_SCALE:   cfg_reg.divider_scale_q8   <= pwdata[15:0];
                REG_EMA_ALPHA:       cfg_reg.ema_alpha_q16      <= pwdata[15:0];
                REG_LOW_START:       cfg_reg.low_start_mv       <= pwdata[15:0];
                REG_ALTERNATOR_MIN:  cfg_reg.alternator_min_mv  <= pwdata[15:0];
                REG_MOCK_ENABLE:     cfg_reg.mock_enable        <= pwdata[0];
                REG_MOCK_MV:         cfg_reg.mock_mv            <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_SAMPLE_INTERVAL: prdata = {16'h0000, cfg_reg.sample_interval_ms};
            REG_DIVIDER_SCALE:   prdata = {16'h0000, cfg_reg.divider_scale_q8};
            REG_EMA_ALPHA:       prdata = {16'h0000, cfg_reg.ema_alpha_q16};
            REG_LOW_START:       prdata = {16'h0000, cfg_reg.low_start_mv};
            REG_ALTERNATOR_MIN:  prdata = {16'h0000, cfg_reg.alternator_min_mv};
            REG_MOCK_ENABLE:     prdata = {31'h0, cfg_reg.mock_enable};
            REG_MOCK_MV:         prdata = {16'h0000, cfg_reg.mock_mv};
            default:             prdata = '0;
        endcase
    end

    // controller
    assign out_free = !m_tvalid_reg || m_tready;

    bvem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    bvem_dp #(
        .WARMUP_SAMPLES (WARMUP_SAMPLES)
    ) u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .cfg                     (cfg_reg),
        .in_now_ms               (s_tdata[31:0]),
        .in_pin_mv               (s_tdata[44:32]),
        .status                  (status),
        .res_sample_taken        (res_sample_taken),
        .res_filtered_mv         (res_filtered_mv),
        .res_reading_valid       (res_reading_valid),
        .res_low_for_start       (res_low_for_start),
        .res_alternator_charging (res_alternator_charging)
    );

    assign s_tready = cmd.in_ready;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {4'h0, res_alternator_charging, res_low_for_start,
                            res_reading_valid, res_filtered_mv, res_sample_taken};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
